// ----- rtl/scancode_set1_to_text_macros.svh -----
// Assertion macros for the scancode set 1 to text translator.
// Depends on nothing; included by the top level only, which provides i_clk and i_rst_n.
`ifndef SCANCODE_SET1_TO_TEXT_MACROS_SVH
`define SCANCODE_SET1_TO_TEXT_MACROS_SVH

// Same-cycle implication on i_clk, disabled while i_rst_n is asserted.
`define SC1T_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication on i_clk, disabled while i_rst_n is asserted.
`define SC1T_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/sc1txt_pkg.sv -----
// Package for the scancode set 1 to text translator: key codes, register
// indexes, widths, the result word type and the two ABNT2 key tables.
`timescale 1ns / 1ps

package sc1txt_pkg;

    // Fixed field widths.
    localparam int STEP_W     = 7;
    localparam int COLOR_W    = 24;
    localparam int DRAW_W     = 16;
    localparam int CHAR_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int COORD_BITS_DEF = 16;

    // Reset values of the configuration registers.
    localparam logic [STEP_W-1:0]  CHAR_WIDTH_RST  = 7'd8;
    localparam logic [STEP_W-1:0]  LINE_HEIGHT_RST = 7'd16;
    localparam logic [COLOR_W-1:0] TEXT_COLOR_RST  = 24'hFFFFFF;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CHAR_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLOR  = 2'd2;

    // Scancode set 1 codes.
    localparam logic [7:0] KEY_PREFIX = 8'hE0;
    localparam logic [6:0] KEY_LSHIFT = 7'h2A;
    localparam logic [6:0] KEY_RSHIFT = 7'h36;
    localparam logic [7:0] KEY_CAPS   = 8'h3A;
    localparam logic [7:0] KEY_NUM    = 8'h45;
    localparam logic [7:0] KEY_UP     = 8'h48;
    localparam logic [7:0] KEY_DOWN   = 8'h50;
    localparam logic [7:0] KEY_LEFT   = 8'h4B;
    localparam logic [7:0] KEY_RIGHT  = 8'h4D;
    localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'd32;

    // One draw command as it sits in the output register or the skid slot.
    typedef struct packed {
        logic signed [DRAW_W-1:0] draw_x;
        logic signed [DRAW_W-1:0] draw_y;
        logic [CHAR_W-1:0]        glyph;
        logic [COLOR_W-1:0]       color;
        logic                     num_lock_on;
    } t_draw_word;

    // Unshifted ABNT2 table.
    function automatic logic [CHAR_W-1:0] plain_char(input logic [6:0] code);
        logic [CHAR_W-1:0] c;
        c = 8'h00;
        case (code)
            7'd1:  c = 8'd27;
            7'd2:  c = "1";
            7'd3:  c = "2";
            7'd4:  c = "3";
            7'd5:  c = "4";
            7'd6:  c = "5";
            7'd7:  c = "6";
            7'd8:  c = "7";
            7'd9:  c = "8";
            7'd10: c = "9";
            7'd11: c = "0";
            7'd12: c = "-";
            7'd13: c = "=";
            7'd14: c = 8'd8;
            7'd15: c = 8'd9;
            7'd16: c = "q";
            7'd17: c = "w";
            7'd18: c = "e";
            7'd19: c = "r";
            7'd20: c = "t";
            7'd21: c = "y";
            7'd22: c = "u";
            7'd23: c = "i";
            7'd24: c = "o";
            7'd25: c = "p";
            7'd26: c = 8'h27;
            7'd27: c = "[";
            7'd28: c = 8'h0A;
            7'd30: c = "a";
            7'd31: c = "s";
            7'd32: c = "d";
            7'd33: c = "f";
            7'd34: c = "g";
            7'd35: c = "h";
            7'd36: c = "j";
            7'd37: c = "k";
            7'd38: c = "l";
            7'd39: c = 8'hE7;
            7'd40: c = "~";
            7'd41: c = "]";
            7'd43: c = 8'h5C;
            7'd44: c = "z";
            7'd45: c = "x";
            7'd46: c = "c";
            7'd47: c = "v";
            7'd48: c = "b";
            7'd49: c = "n";
            7'd50: c = "m";
            7'd51: c = ",";
            7'd52: c = ".";
            7'd53: c = ";";
            7'd55: c = "*";
            7'd57: c = " ";
            7'd71: c = "/";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Shifted ABNT2 table.
    function automatic logic [CHAR_W-1:0] shift_char(input logic [6:0] code);
        logic [CHAR_W-1:0] c;
        c = 8'h00;
        case (code)
            7'd1:  c = 8'd27;
            7'd2:  c = "!";
            7'd3:  c = "@";
            7'd4:  c = "#";
            7'd5:  c = "$";
            7'd6:  c = "%";
            7'd7:  c = "^";
            7'd8:  c = "&";
            7'd9:  c = "*";
            7'd10: c = "(";
            7'd11: c = ")";
            7'd12: c = "_";
            7'd13: c = "+";
            7'd14: c = 8'd8;
            7'd15: c = 8'd9;
            7'd16: c = "Q";
            7'd17: c = "W";
            7'd18: c = "E";
            7'd19: c = "R";
            7'd20: c = "T";
            7'd21: c = "Y";
            7'd22: c = "U";
            7'd23: c = "I";
            7'd24: c = "O";
            7'd25: c = "P";
            7'd26: c = 8'h22;
            7'd27: c = "{";
            7'd28: c = 8'h0A;
            7'd30: c = "A";
            7'd31: c = "S";
            7'd32: c = "D";
            7'd33: c = "F";
            7'd34: c = "G";
            7'd35: c = "H";
            7'd36: c = "J";
            7'd37: c = "k";
            7'd38: c = "L";
            7'd39: c = 8'hC7;
            7'd40: c = "^";
            7'd41: c = "}";
            7'd43: c = "|";
            7'd44: c = "Z";
            7'd45: c = "X";
            7'd46: c = "C";
            7'd47: c = "V";
            7'd48: c = "B";
            7'd49: c = "N";
            7'd50: c = "M";
            7'd51: c = "<";
            7'd52: c = ">";
            7'd53: c = ":";
            7'd55: c = "*";
            7'd57: c = " ";
            7'd71: c = "?";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/sc1txt_keymap.sv -----
// Key translation: make code plus shift and caps state to a Latin-1 byte.
// Depends on sc1txt_pkg for the two key tables.
`timescale 1ns / 1ps

module sc1txt_keymap
    import sc1txt_pkg::*;
(
    input  logic [6:0]        i_code,
    input  logic              i_shift,
    input  logic              i_caps,
    output logic [CHAR_W-1:0] o_char
);

    logic [CHAR_W-1:0] w_plain;
    logic              w_letter;

    assign w_plain  = plain_char(i_code);
    assign w_letter = (w_plain >= "a") && (w_plain <= "z");

    // Letters follow caps XOR shift; other keys take the shift table only under shift.
    always_comb begin
        if (w_letter) begin
            o_char = (i_caps ^ i_shift) ? (w_plain - CASE_OFFSET) : w_plain;
        end else if (i_shift) begin
            o_char = shift_char(i_code);
        end else begin
            o_char = w_plain;
        end
    end

endmodule

// ----- rtl/sc1txt_sat_step.sv -----
// Saturating cursor step: moves a signed coordinate by an unsigned step.
// Depends on sc1txt_pkg for the step width.
`timescale 1ns / 1ps

module sc1txt_sat_step
    import sc1txt_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic signed [COORD_BITS-1:0] i_pos,
    input  logic        [STEP_W-1:0]     i_step,
    input  logic                         i_neg,
    output logic signed [COORD_BITS-1:0] o_pos
);

    localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] COORD_MIN = ~COORD_MAX;

    logic signed [COORD_BITS:0] w_pos;
    logic signed [COORD_BITS:0] w_delta;
    logic signed [COORD_BITS:0] w_sum;

    // One guard bit holds the exact sum; its top two bits show overflow.
    assign w_pos   = (COORD_BITS+1)'(i_pos);
    assign w_delta = signed'((COORD_BITS+1)'(i_step));
    assign w_sum   = i_neg ? (w_pos - w_delta) : (w_pos + w_delta);

    always_comb begin
        if (w_sum[COORD_BITS] != w_sum[COORD_BITS-1]) begin
            o_pos = w_sum[COORD_BITS] ? COORD_MIN : COORD_MAX;
        end else begin
            o_pos = w_sum[COORD_BITS-1:0];
        end
    end

endmodule

// ----- rtl/scancode_set1_to_text.sv -----
// Top level of the scancode set 1 to text translator: key state, cursor,
// configuration and output buffering. Uses sc1txt_pkg, sc1txt_keymap,
// sc1txt_sat_step and the assertion macros header.
//
//   channel  direction  handshake                  payload
//   in       upstream   i_in_valid / o_in_stall    i_scan_byte
//   out      downstream o_out_valid / i_out_stall  o_draw_x o_draw_y o_glyph o_color
//                                                  o_num_lock_on
//   cfg      upstream   i_cfg_we                   i_cfg_index i_cfg_data
//
// One byte is accepted per cycle while o_in_stall is low; its draw word goes
// to the output register, or to the one-word skid slot behind it while the
// output stalls, which keeps input flowing. Table lookup and the cursor adder
// are combinational. Reset is synchronous; no clearing pass is needed.
// o_in_stall rises only while the skid slot is occupied.
`timescale 1ns / 1ps

module scancode_set1_to_text
    import sc1txt_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [7:0]               i_scan_byte,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [DRAW_W-1:0] o_draw_x,
    output logic signed [DRAW_W-1:0] o_draw_y,
    output logic [CHAR_W-1:0]        o_glyph,
    output logic [COLOR_W-1:0]       o_color,
    output logic                     o_num_lock_on,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [COLOR_W-1:0]       i_cfg_data
);

`include "scancode_set1_to_text_macros.svh"

    // Configuration registers.
    logic [STEP_W-1:0]  r_char_width;
    logic [STEP_W-1:0]  r_line_height;
    logic [COLOR_W-1:0] r_text_color;

    // Key and cursor state.
    logic r_ext, n_ext;
    logic r_shift, n_shift;
    logic r_caps, n_caps;
    logic r_num, n_num;
    logic signed [COORD_BITS-1:0] r_col, n_col;
    logic signed [COORD_BITS-1:0] r_row, n_row;

    // Output register and skid slot.
    logic       r_out_valid;
    t_draw_word r_out;
    logic       r_skid_valid;
    t_draw_word r_skid;

    logic              w_in_fire;
    logic              w_out_fire;
    logic [CHAR_W-1:0] w_char;
    logic              w_res_valid;
    t_draw_word        w_res;
    logic signed [COORD_BITS-1:0] w_col_step;
    logic signed [COORD_BITS-1:0] w_row_step;
    logic signed [31:0] w_col_ext;
    logic signed [31:0] w_row_ext;
    logic              w_col_neg;
    logic              w_row_neg;
    logic              w_prefix_in;
    logic              w_after_prefix;

    assign w_in_fire  = i_in_valid && !o_in_stall;
    assign w_out_fire = r_out_valid && !i_out_stall;
    assign o_in_stall = r_skid_valid;

    // Configuration writes; an index past the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_width  <= CHAR_WIDTH_RST;
            r_line_height <= LINE_HEIGHT_RST;
            r_text_color  <= TEXT_COLOR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CHAR_WIDTH:  r_char_width  <= i_cfg_data[STEP_W-1:0];
                CFG_LINE_HEIGHT: r_line_height <= i_cfg_data[STEP_W-1:0];
                CFG_TEXT_COLOR:  r_text_color  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    sc1txt_keymap u_keymap (
        .i_code  (i_scan_byte[6:0]),
        .i_shift (r_shift),
        .i_caps  (r_caps),
        .o_char  (w_char)
    );

    // Column moves by left/right arrows and by character advance; row by up/down.
    assign w_col_neg = (i_scan_byte == KEY_LEFT);
    assign w_row_neg = (i_scan_byte == KEY_UP);

    sc1txt_sat_step #(.COORD_BITS(COORD_BITS)) u_col_step (
        .i_pos  (r_col),
        .i_step (r_char_width),
        .i_neg  (w_col_neg),
        .o_pos  (w_col_step)
    );

    sc1txt_sat_step #(.COORD_BITS(COORD_BITS)) u_row_step (
        .i_pos  (r_row),
        .i_step (r_line_height),
        .i_neg  (w_row_neg),
        .o_pos  (w_row_step)
    );

    // The drawn position is the low bits of the sign-extended cursor.
    assign w_col_ext = 32'(r_col);
    assign w_row_ext = 32'(r_row);

    always_comb begin
        w_res.draw_x      = w_col_ext[DRAW_W-1:0];
        w_res.draw_y      = w_row_ext[DRAW_W-1:0];
        w_res.glyph       = w_char;
        w_res.color       = r_text_color;
        w_res.num_lock_on = r_num;
    end

    // Byte decode: prefix, arrow after prefix, break, lock and shift keys, text.
    always_comb begin
        n_ext       = r_ext;
        n_shift     = r_shift;
        n_caps      = r_caps;
        n_num       = r_num;
        n_col       = r_col;
        n_row       = r_row;
        w_res_valid = 1'b0;
        if (w_in_fire) begin
            priority if (i_scan_byte == KEY_PREFIX) begin
                n_ext = 1'b1;
            end else if (r_ext) begin
                n_ext = 1'b0;
                if (i_scan_byte == KEY_UP || i_scan_byte == KEY_DOWN) begin
                    n_row = w_row_step;
                end else if (i_scan_byte == KEY_LEFT || i_scan_byte == KEY_RIGHT) begin
                    n_col = w_col_step;
                end
            end else if (i_scan_byte[7]) begin
                if (i_scan_byte[6:0] == KEY_LSHIFT || i_scan_byte[6:0] == KEY_RSHIFT) begin
                    n_shift = 1'b0;
                end
            end else if (i_scan_byte == KEY_CAPS) begin
                n_caps = !r_caps;
            end else if (i_scan_byte == KEY_NUM) begin
                n_num = !r_num;
            end else if (i_scan_byte[6:0] == KEY_LSHIFT ||
                         i_scan_byte[6:0] == KEY_RSHIFT) begin
                n_shift = 1'b1;
            end else begin
                // Text key; an unmapped key gives no word.
                w_res_valid = (w_char != '0);
                if (w_res_valid) begin
                    n_col = w_col_step;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ext   <= 1'b0;
            r_shift <= 1'b0;
            r_caps  <= 1'b0;
            r_num   <= 1'b0;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            r_ext   <= n_ext;
            r_shift <= n_shift;
            r_caps  <= n_caps;
            r_num   <= n_num;
            r_col   <= n_col;
            r_row   <= n_row;
        end
    end

    // Output register with skid slot: the slot fills only while the output stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || w_out_fire) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_res_valid;
            end
        end else if (w_res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_out_fire) begin
            r_out <= r_skid_valid ? r_skid : w_res;
        end else if (w_res_valid) begin
            r_skid <= w_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_draw_x      = r_out.draw_x;
    assign o_draw_y      = r_out.draw_y;
    assign o_glyph       = r_out.glyph;
    assign o_color       = r_out.color;
    assign o_num_lock_on = r_out.num_lock_on;

    // Checks on the buffering and prefix handling.
    assign w_prefix_in    = w_in_fire && (i_scan_byte == KEY_PREFIX);
    assign w_after_prefix = w_in_fire && r_ext && (i_scan_byte != KEY_PREFIX);

    `SC1T_ASSERT_IMPL(a_skid_needs_out, r_skid_valid, r_out_valid, "skid full, output empty")
    `SC1T_ASSERT_NEXT(a_skid_holds, r_skid_valid && i_out_stall, r_skid_valid, "skid word lost")
    `SC1T_ASSERT_NEXT(a_prefix_sets, w_prefix_in, r_ext, "prefix byte did not set the flag")
    `SC1T_ASSERT_NEXT(a_prefix_clears, w_after_prefix, !r_ext, "prefix flag not cleared")

endmodule

// ----- test/tb_scancode_set1_to_text.sv -----
// Self-checking testbench for scancode_set1_to_text: a queue-fed byte driver,
// a random-stall draw receiver and a behavioral key and cursor predictor.
// Depends on sc1txt_pkg and the scancode_set1_to_text RTL only.
`timescale 1ns / 1ps

module tb_scancode_set1_to_text;
    import sc1txt_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 300;
    localparam int KEYMAP_LEN    = 80;
    localparam int COORD_MAX     = (1 << (COORD_BITS_DEF - 1)) - 1;
    localparam int COORD_MIN     = -(1 << (COORD_BITS_DEF - 1));

    // Index 3 is decoded by nothing; writes to it must leave all state alone.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // ABNT2 layout, codes 0 to 79; every code above that maps to nothing.
    localparam logic [0:KEYMAP_LEN-1][7:0] KEYMAP_PLAIN = {
        8'h00, 8'h1B, "1", "2", "3", "4", "5", "6",
        "7", "8", "9", "0", "-", "=", 8'h08, 8'h09,
        "q", "w", "e", "r", "t", "y", "u", "i",
        "o", "p", 8'h27, "[", 8'h0A, 8'h00, "a", "s",
        "d", "f", "g", "h", "j", "k", "l", 8'hE7,
        "~", "]", 8'h00, 8'h5C, "z", "x", "c", "v",
        "b", "n", "m", ",", ".", ";", 8'h00, "*",
        8'h00, " ", {6{8'h00}},
        {7{8'h00}}, "/",
        {8{8'h00}}
    };

    localparam logic [0:KEYMAP_LEN-1][7:0] KEYMAP_SHIFT = {
        8'h00, 8'h1B, "!", "@", "#", "$", "%", "^",
        "&", "*", "(", ")", "_", "+", 8'h08, 8'h09,
        "Q", "W", "E", "R", "T", "Y", "U", "I",
        "O", "P", 8'h22, "{", 8'h0A, 8'h00, "A", "S",
        "D", "F", "G", "H", "J", "k", "L", 8'hC7,
        "^", "}", 8'h00, "|", "Z", "X", "C", "V",
        "B", "N", "M", "<", ">", ":", 8'h00, "*",
        8'h00, " ", {6{8'h00}},
        {7{8'h00}}, "?",
        {8{8'h00}}
    };

    // Opening sequence: case rules, shift and caps interplay, num lock,
    // unmapped codes, a doubled prefix, prefixed non-arrows and arrow breaks.
    localparam int WARMUP_LEN = 26;
    localparam logic [0:WARMUP_LEN-1][7:0] WARMUP_KEYS = {
        8'h1E, 8'h02, {1'b0, KEY_LSHIFT}, 8'h1E, 8'h02, 8'h25,
        {1'b1, KEY_LSHIFT}, KEY_CAPS, 8'h10, {1'b0, KEY_RSHIFT}, 8'h10, 8'h0C,
        {1'b1, KEY_RSHIFT}, KEY_NUM, 8'h00, 8'h27,
        KEY_PREFIX, KEY_PREFIX, KEY_UP,
        KEY_PREFIX, KEY_UP | 8'h80,
        KEY_PREFIX, 8'h1E, 8'hFF,
        KEY_PREFIX, KEY_LEFT
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [7:0]           i_scan_byte = 8'h00;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic signed [DRAW_W-1:0] o_draw_x;
    logic signed [DRAW_W-1:0] o_draw_y;
    logic [CHAR_W-1:0]    o_glyph;
    logic [COLOR_W-1:0]   o_color;
    logic                 o_num_lock_on;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [COLOR_W-1:0]   i_cfg_data = '0;

    // Stimulus and scoreboard storage.
    logic [7:0]  scan_queue[$];
    t_draw_word  expected_draws[$];
    int          fail_count = 0;
    int          cycle_count = 0;

    // Handshake flags, set at the rising edge and used at the falling edge.
    bit          key_taken = 1'b0;
    bit          draw_taken = 1'b0;

    // Pacing controls, changed by the sequence only at rising edges.
    int          in_gap_max = 0;
    int          out_gap_max = 0;
    int          hold_asked = 0;

    // Driver and receiver internals.
    bit          key_busy = 1'b0;
    int          key_gap = 0;
    logic [7:0]  key_byte = 8'h00;
    int          draw_gap = 0;
    int          hold_left = 0;
    int          hold_served = 0;
    logic        hold_on = 1'b0;

    // Predicted keyboard, cursor and register state.
    bit          ext_pending = 1'b0;
    bit          shift_down = 1'b0;
    bit          caps_state = 1'b0;
    bit          numlk_state = 1'b0;
    int          cur_col = 0;
    int          cur_row = 0;
    logic [STEP_W-1:0]  step_x = CHAR_WIDTH_RST;
    logic [STEP_W-1:0]  step_y = LINE_HEIGHT_RST;
    logic [COLOR_W-1:0] ink = TEXT_COLOR_RST;

    scancode_set1_to_text uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_scan_byte   (i_scan_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_draw_x      (o_draw_x),
        .o_draw_y      (o_draw_y),
        .o_glyph       (o_glyph),
        .o_color       (o_color),
        .o_num_lock_on (o_num_lock_on),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Cursor arithmetic clamps at the signed coordinate range.
    function automatic int sat_coord(input int pos);
        if (pos > COORD_MAX) return COORD_MAX;
        if (pos < COORD_MIN) return COORD_MIN;
        return pos;
    endfunction

    // Advances the predicted state by one scan byte and queues the draw word
    // that it produces, if any.
    function automatic void predict_key(input logic [7:0] code);
        logic [7:0] ch;
        t_draw_word word;
        if (code == KEY_PREFIX) begin
            ext_pending = 1'b1;
            return;
        end
        if (ext_pending) begin
            ext_pending = 1'b0;
            case (code)
                KEY_UP:    cur_row = sat_coord(cur_row - int'(step_y));
                KEY_DOWN:  cur_row = sat_coord(cur_row + int'(step_y));
                KEY_LEFT:  cur_col = sat_coord(cur_col - int'(step_x));
                KEY_RIGHT: cur_col = sat_coord(cur_col + int'(step_x));
                default: ;
            endcase
            return;
        end
        if (code[7]) begin
            if (code[6:0] == KEY_LSHIFT || code[6:0] == KEY_RSHIFT) shift_down = 1'b0;
            return;
        end
        if (code == KEY_CAPS) begin
            caps_state = !caps_state;
            return;
        end
        if (code == KEY_NUM) begin
            numlk_state = !numlk_state;
            return;
        end
        if (code[6:0] == KEY_LSHIFT || code[6:0] == KEY_RSHIFT) begin
            shift_down = 1'b1;
            return;
        end

        // Letters follow caps XOR shift; everything else follows shift alone.
        ch = (code < KEYMAP_LEN) ? KEYMAP_PLAIN[code[6:0]] : 8'h00;
        if (ch >= "a" && ch <= "z") begin
            if (caps_state != shift_down) ch = ch - CASE_OFFSET;
        end else if (shift_down) begin
            ch = (code < KEYMAP_LEN) ? KEYMAP_SHIFT[code[6:0]] : 8'h00;
        end
        if (ch == 8'h00) return;

        word.draw_x      = cur_col[DRAW_W-1:0];
        word.draw_y      = cur_row[DRAW_W-1:0];
        word.glyph       = ch;
        word.color       = ink;
        word.num_lock_on = numlk_state;
        expected_draws.push_back(word);
        cur_col = sat_coord(cur_col + int'(step_x));
    endfunction

    // Monitor: checks each accepted draw word, then predicts from each
    // accepted scan byte.
    always @(posedge i_clk) begin : monitor
        t_draw_word want;
        key_taken  = i_rst_n && i_in_valid && !o_in_stall;
        draw_taken = i_rst_n && o_out_valid && !i_out_stall;
        if (draw_taken) begin
            if (expected_draws.size() == 0) begin
                fail_count++;
                $error("unexpected draw word: glyph %02h at (%0d, %0d)",
                       o_glyph, o_draw_x, o_draw_y);
            end else begin
                want = expected_draws.pop_front();
                if (o_draw_x !== want.draw_x) begin
                    fail_count++;
                    $error("draw_x: expected %0d, got %0d", want.draw_x, o_draw_x);
                end
                if (o_draw_y !== want.draw_y) begin
                    fail_count++;
                    $error("draw_y: expected %0d, got %0d", want.draw_y, o_draw_y);
                end
                if (o_glyph !== want.glyph) begin
                    fail_count++;
                    $error("glyph: expected %02h, got %02h", want.glyph, o_glyph);
                end
                if (o_color !== want.color) begin
                    fail_count++;
                    $error("color: expected %06h, got %06h", want.color, o_color);
                end
                if (o_num_lock_on !== want.num_lock_on) begin
                    fail_count++;
                    $error("num_lock_on: expected %0b, got %0b",
                           want.num_lock_on, o_num_lock_on);
                end
            end
        end
        if (key_taken) predict_key(i_scan_byte);
    end

    // Driver: presents queued scan bytes with a random gap before each byte.
    always @(negedge i_clk) begin : key_driver
        if (key_taken) begin
            key_busy = 1'b0;
            key_gap  = $urandom_range(0, in_gap_max);
        end
        if (!key_busy && i_rst_n) begin
            if (key_gap > 0) begin
                key_gap--;
            end else if (scan_queue.size() > 0) begin
                key_byte = scan_queue.pop_front();
                key_busy = 1'b1;
            end
        end
        i_in_valid  <= key_busy;
        i_scan_byte <= key_byte;
    end

    // Receiver: stalls a random number of cycles after each draw word, and
    // also for as long as a hold-off is running.
    always @(negedge i_clk) begin : draw_receiver
        if (draw_taken) draw_gap = $urandom_range(0, out_gap_max);
        i_out_stall <= (draw_gap > 0) || hold_on;
        if (draw_gap > 0) draw_gap--;
    end

    // Long output hold-off, so that the skid slot fills and the input stalls.
    always @(negedge i_clk) begin : hold_timer
        if (hold_left == 0 && hold_served != hold_asked) begin
            hold_left = HOLD_CYCLES;
            hold_served++;
        end else if (hold_left > 0) begin
            hold_left--;
        end
        hold_on <= (hold_left > 0);
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** scancode_set1_to_text: FAILED **");
            $finish;
        end
    end

    // Writes one register between falling edges and mirrors it.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_CHAR_WIDTH:  step_x = val[STEP_W-1:0];
            CFG_LINE_HEIGHT: step_y = val[STEP_W-1:0];
            CFG_TEXT_COLOR:  ink = val;
            default: ;
        endcase
    endtask

    // Waits until every byte is taken and every draw word has arrived, then
    // lets the pipeline run dry.
    task automatic settle();
        while (scan_queue.size() != 0 || key_busy || expected_draws.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Queues random typing. With a bias key, that share of the sequences is
    // a prefixed arrow in one direction, which drives the cursor to a limit.
    task automatic queue_typing(input int n_keys, input logic [7:0] bias_key,
                                input int bias_pct);
        int         start;
        int         pick;
        int         n;
        logic [7:0] b;
        logic [7:0] sh;
        start = scan_queue.size();
        while (scan_queue.size() - start < n_keys) begin
            pick = $urandom_range(0, 99);
            if (pick < bias_pct) begin
                scan_queue.push_back(KEY_PREFIX);
                scan_queue.push_back(bias_key);
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 30) begin
                    // Keys of the letter rows.
                    b = 8'($urandom_range(16, 50));
                    scan_queue.push_back(b);
                end else if (pick < 45) begin
                    b = 8'($urandom_range(0, 127));
                    scan_queue.push_back(b);
                end else if (pick < 55) begin
                    // A shifted word: press, a few keys, release.
                    sh = $urandom_range(0, 1) ? {1'b0, KEY_LSHIFT} : {1'b0, KEY_RSHIFT};
                    scan_queue.push_back(sh);
                    n = $urandom_range(1, 4);
                    repeat (n) begin
                        b = 8'($urandom_range(0, 57));
                        scan_queue.push_back(b);
                    end
                    scan_queue.push_back(sh | 8'h80);
                end else if (pick < 60) begin
                    b = {1'($urandom_range(0, 1)),
                         $urandom_range(0, 1) ? KEY_LSHIFT : KEY_RSHIFT};
                    scan_queue.push_back(b);
                end else if (pick < 65) begin
                    scan_queue.push_back(KEY_CAPS);
                end else if (pick < 68) begin
                    scan_queue.push_back(KEY_NUM);
                end else if (pick < 82) begin
                    case ($urandom_range(0, 3))
                        0:       b = KEY_UP;
                        1:       b = KEY_DOWN;
                        2:       b = KEY_LEFT;
                        default: b = KEY_RIGHT;
                    endcase
                    scan_queue.push_back(KEY_PREFIX);
                    scan_queue.push_back(b);
                end else if (pick < 87) begin
                    // Prefix followed by anything, arrow breaks and prefixes too.
                    b = 8'($urandom_range(0, 255));
                    scan_queue.push_back(KEY_PREFIX);
                    scan_queue.push_back(b);
                end else if (pick < 93) begin
                    b = 8'($urandom_range(128, 255));
                    scan_queue.push_back(b);
                end else begin
                    b = 8'($urandom_range(0, 255));
                    scan_queue.push_back(b);
                end
            end
        end
    endtask

    // One phase: drain, set the registers, set the pacing and queue typing.
    task automatic run_phase(input logic [COLOR_W-1:0] cw, input logic [COLOR_W-1:0] lh,
                             input logic [COLOR_W-1:0] color, input int n_keys,
                             input logic [7:0] bias_key, input int bias_pct,
                             input int in_max, input int out_max);
        settle();
        write_reg(CFG_CHAR_WIDTH, cw);
        write_reg(CFG_LINE_HEIGHT, lh);
        write_reg(CFG_TEXT_COLOR, color);
        @(posedge i_clk);
        in_gap_max  = in_max;
        out_gap_max = out_max;
        queue_typing(n_keys, bias_key, bias_pct);
    endtask

    initial begin : sequence_main
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed keys at the reset register values.
        in_gap_max  = 2;
        out_gap_max = 2;
        for (int i = 0; i < WARMUP_LEN; i++) scan_queue.push_back(WARMUP_KEYS[i]);

        // Unit steps and black ink; the receiver holds off for a long stretch
        // while bytes keep coming back to back.
        run_phase(24'd1, 24'd1, 24'h000000, 250, 8'h00, 0, 0, 7);
        hold_asked++;

        // Largest steps, mostly up arrows: the row saturates low.
        run_phase(24'd127, 24'd127, 24'($urandom()), 600, KEY_UP, 90, 7, 7);

        // Zero steps with junk in the upper data bits, plus a write to the
        // undecoded index; no idling on either side.
        settle();
        write_reg(CFG_UNUSED, 24'($urandom()));
        run_phase(24'hFFFF80, 24'h5A5A00, 24'hFFFFFF, 100, 8'h00, 0, 0, 0);

        // Largest character step, mostly right arrows: the column saturates high.
        run_phase(24'h00007F, 24'd64, 24'($urandom()), 550, KEY_RIGHT, 90, 3, 0);

        // Ordinary settings.
        run_phase(24'($urandom_range(1, 64)), 24'($urandom_range(1, 64)), 24'($urandom()),
                  200, 8'h00, 0, 7, 3);

        settle();
        if (fail_count == 0) begin
            $display("** scancode_set1_to_text: PASSED **");
        end else begin
            $display("** scancode_set1_to_text: FAILED **");
        end
        $finish;
    end

endmodule
